@@ rtl/core/assert_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the checker file.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("stream check failed");

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("stream check failed");

// Property that must follow a reset cycle.
`define ASSERT_AFTER_RESET(label, clk, rst, cons) \
  label: assert property (@(posedge clk) (rst) |=> (cons)) \
    else $error("reset check failed");

`endif

@@ rtl/core/srgb_lab_pkg.sv @@
// ---------------------------------------------------------------------------
// srgb_lab_pkg
// Widths, constants, types and elaboration helpers of the sRGB to CIELAB
// converter.
// ---------------------------------------------------------------------------
package srgb_lab_pkg;

  localparam int CHANNEL_BITS_DEF = 8;
  localparam int QBITS     = 24;
  localparam int LIN_W     = 25;
  localparam int SUM_W     = 38;
  localparam int NUM_SHIFT = 6;
  localparam int NUM_W     = SUM_W + NUM_SHIFT;
  localparam int DIV_W     = 20;
  localparam int DIV_STEPS = 4;
  localparam int DIV_STAGES = NUM_W / DIV_STEPS;
  localparam int T_W       = 40;
  localparam int ROOT_W    = 29;
  localparam int SQ_W      = 34;
  localparam int CUBE_W    = 39;
  localparam int KNEE_BITS = 18;
  localparam int PROD_W    = 31;
  localparam int RECIP_W   = 32;
  localparam int RECIP_SHIFT = 41;
  localparam int LF_W      = 22;
  localparam int LAB_W     = 40;
  localparam int OUT_W     = 16;
  localparam int WHITE_W   = 15;
  localparam int CFG_IDX_W = 2;
  localparam int OUT_DATA_W = 3 * OUT_W;

  localparam logic [WHITE_W-1:0] WHITE_X_RST = 15'd24332;
  localparam logic [WHITE_W-1:0] WHITE_Y_RST = 15'd25600;
  localparam logic [WHITE_W-1:0] WHITE_Z_RST = 15'd27874;
  localparam logic [DIV_W-1:0]   WHITE_SCALE = 20'd25;

  // Largest t still on the linear segment of the Lab function.
  localparam logic [T_W-1:0]     KNEE_T     = 40'd148579;
  localparam logic [PROD_W-1:0]  LIN_SLOPE  = 31'd7787;
  localparam logic [RECIP_W-1:0] RECIP_1000 = 32'd2199023256;
  localparam logic [LF_W-1:0]    LIN_OFFSET = 22'd2314098;

  localparam int L_SCALE  = 116;
  localparam int A_SCALE  = 500;
  localparam int B_SCALE  = 200;
  localparam int L_OFFSET = 268435456;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WHITE_X = 2'd0,
    REG_WHITE_Y = 2'd1,
    REG_WHITE_Z = 2'd2
  } cfg_index_t;

  typedef logic [13:0] coef_t;

  // sRGB to XYZ matrix, coefficients times 10000.
  localparam coef_t MAT [3][3] = '{
    '{14'd4124, 14'd3576, 14'd1805},
    '{14'd2126, 14'd7152, 14'd722},
    '{14'd193,  14'd1192, 14'd9505}
  };

  typedef struct packed {
    logic [OUT_W-1:0] blue_yellow;
    logic [OUT_W-1:0] green_red;
    logic [OUT_W-1:0] lightness;
  } lab_out_t;

  function automatic longint unsigned mulq(longint unsigned a, longint unsigned b);
    return (a * b) >> QBITS;
  endfunction

  // Upper gamma segment: u^2 times the fifth root of u^2, all truncated Q24.
  function automatic longint unsigned gamma_high(longint unsigned u);
    longint unsigned u2;
    longint unsigned r;
    longint unsigned t;
    longint unsigned p;
    u2 = mulq(u, u);
    r = 0;
    for (int b = QBITS; b >= 0; b--) begin
      t = r | (64'd1 << b);
      p = mulq(mulq(mulq(mulq(t, t), t), t), t);
      if (p <= u2) begin
        r = t;
      end
    end
    return mulq(u2, r);
  endfunction

endpackage

@@ rtl/core/srgb_to_cielab_unit.sv @@
// ---------------------------------------------------------------------------
// srgb_to_cielab_unit
// sRGB pixel to CIELAB converter with a programmable reference white.
// ---------------------------------------------------------------------------
// The slave stream carries one pixel per transfer, red, green and blue packed
// from the lowest bit up. The master stream returns L, a and b as signed
// values with 8 fractional bits, saturated to 16 bits. The configuration
// channel writes the reference white X, Y and Z (index 0, 1, 2); writes to
// any other index are dropped, and cfg_ready is always high. Configuration
// must only change while no pixel is in flight.
// Every pixel is independent, and the pipeline takes one pixel per clock while
// s_tready is high. A pixel passes in order through the gamma lookup and
// matrix registers, eleven divider stages at four quotient bits each,
// fifty-eight cube root stages (a square and a cube step for each of the 29
// root bits), the registers forming L, a and b, and the output register.
// Reset empties the pipeline and restores the D65 white point.
// When the receiver stalls, the output register holds its result and a skid
// register catches the next one; only then does s_tready drop and the whole
// pipeline freeze in place, so no pixel is lost or repeated.
// ---------------------------------------------------------------------------
module srgb_to_cielab_unit #(
  parameter int CHANNEL_BITS = srgb_lab_pkg::CHANNEL_BITS_DEF,
  localparam int InDataW = ((3 * CHANNEL_BITS + 7) / 8) * 8
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [InDataW-1:0]                  s_tdata,  // red, green, blue, zero fill
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [srgb_lab_pkg::OUT_DATA_W-1:0] m_tdata,  // lightness, green_red, blue_yellow
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [srgb_lab_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [srgb_lab_pkg::WHITE_W-1:0]    cfg_data
);
  import srgb_lab_pkg::*;

  logic [WHITE_W-1:0] white [3];
  logic [DIV_W-1:0]   divisor [3];
  logic [CHANNEL_BITS-1:0] chan [3];
  logic               en;
  logic               lin_valid;
  logic [SUM_W-1:0]   sum [3];
  logic [NUM_W-1:0]   num [3];
  logic               div_valid;
  logic [T_W-1:0]     t_div [3];
  logic               root_valid;
  logic [ROOT_W-1:0]  root [3];
  logic [T_W-1:0]     t_root [3];
  lab_out_t           result;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      white[0] <= WHITE_X_RST;
      white[1] <= WHITE_Y_RST;
      white[2] <= WHITE_Z_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_WHITE_X: white[0] <= cfg_data;
        REG_WHITE_Y: white[1] <= cfg_data;
        REG_WHITE_Z: white[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  // A zero white acts as the smallest nonzero white. The user keeps the divisor steady
  // while pixels are in flight (not enforced here); every divider stage reads it directly.
  for (genvar l = 0; l < 3; l++) begin : g_lane
    assign divisor[l] = DIV_W'((white[l] == '0) ? WHITE_W'(1) : white[l]) * WHITE_SCALE;
    assign chan[l]    = s_tdata[l*CHANNEL_BITS +: CHANNEL_BITS];
    assign num[l]     = {sum[l], NUM_SHIFT'(0)};
  end

  assign s_tready = en;

  srgb_lab_linearize #(
    .CHANNEL_BITS(CHANNEL_BITS)
  ) u_linearize (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s_tvalid),
    .chan      (chan),
    .out_valid (lin_valid),
    .sum       (sum)
  );

  srgb_lab_divide u_divide (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (lin_valid),
    .num       (num),
    .divisor   (divisor),
    .out_valid (div_valid),
    .quo       (t_div)
  );

  srgb_lab_cbrt u_cbrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (div_valid),
    .t_in      (t_div),
    .out_valid (root_valid),
    .root      (root),
    .t_out     (t_root)
  );

  srgb_lab_output u_output (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (root_valid),
    .root      (root),
    .t_in      (t_root),
    .m_tready  (m_tready),
    .m_tvalid  (m_tvalid),
    .result    (result),
    .advance   (en)
  );

  assign m_tdata = result;

endmodule

@@ rtl/core/srgb_lab_linearize.sv @@
// ---------------------------------------------------------------------------
// srgb_lab_linearize
// Gamma lookup per channel followed by the XYZ matrix, three stages.
// ---------------------------------------------------------------------------
module srgb_lab_linearize #(
  parameter int CHANNEL_BITS = srgb_lab_pkg::CHANNEL_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           en,
  input  logic                           in_valid,
  input  logic [CHANNEL_BITS-1:0]        chan [3],
  output logic                           out_valid,
  output logic [srgb_lab_pkg::SUM_W-1:0] sum [3]
);
  import srgb_lab_pkg::*;

  localparam int Depth = 2 ** CHANNEL_BITS;
  localparam longint unsigned Full = (64'd1 << CHANNEL_BITS) - 64'd1;

  logic [LIN_W-1:0] lut [Depth];

  for (genvar g = 0; g < Depth; g++) begin : g_lut
    localparam longint unsigned Code = 64'(g);
    localparam longint unsigned U = ((1000 * Code + 55 * Full) << QBITS) / (1055 * Full);
    localparam longint unsigned Low = ((Code * 100) << QBITS) / (Full * 1292);
    localparam logic [LIN_W-1:0] Value =
      (100000 * Code > 4045 * Full) ? LIN_W'(gamma_high(U)) : LIN_W'(Low);
    assign lut[g] = Value;
  end

  logic [LIN_W-1:0] lin [3];
  logic [SUM_W-1:0] prod [3][3];
  logic             v1;
  logic             v2;
  logic             v3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        lin[i] <= lut[chan[i]];
        for (int j = 0; j < 3; j++) begin
          prod[i][j] <= SUM_W'(MAT[i][j]) * SUM_W'(lin[j]);
        end
        sum[i] <= prod[i][0] + prod[i][1] + prod[i][2];
      end
    end
  end

  assign out_valid = v3;

endmodule

@@ rtl/core/srgb_lab_divide.sv @@
// ---------------------------------------------------------------------------
// srgb_lab_divide
// Pipelined restoring divider, three lanes, a few quotient bits per stage.
// ---------------------------------------------------------------------------
module srgb_lab_divide (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           en,
  input  logic                           in_valid,
  input  logic [srgb_lab_pkg::NUM_W-1:0] num [3],
  input  logic [srgb_lab_pkg::DIV_W-1:0] divisor [3],
  output logic                           out_valid,
  output logic [srgb_lab_pkg::T_W-1:0]   quo [3]
);
  import srgb_lab_pkg::*;

  logic [DIV_W-1:0] rem_q [DIV_STAGES][3];
  logic [NUM_W-1:0] nq_q  [DIV_STAGES][3];
  logic             v_q   [DIV_STAGES];

  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
    logic [DIV_W-1:0] rem_in [3];
    logic [NUM_W-1:0] nq_in  [3];
    logic             v_in;
    logic [DIV_W-1:0] rem_nx [3];
    logic [NUM_W-1:0] nq_nx  [3];

    if (s == 0) begin : g_first
      assign v_in = in_valid;
      for (genvar l = 0; l < 3; l++) begin : g_lane
        assign rem_in[l] = '0;
        assign nq_in[l]  = num[l];
      end
    end else begin : g_rest
      assign v_in = v_q[s-1];
      for (genvar l = 0; l < 3; l++) begin : g_lane
        assign rem_in[l] = rem_q[s-1][l];
        assign nq_in[l]  = nq_q[s-1][l];
      end
    end

    // The dividend shifts out at the top while quotient bits shift in below.
    always_comb begin
      logic [DIV_W:0] trial;
      trial = '0;
      for (int l = 0; l < 3; l++) begin
        rem_nx[l] = rem_in[l];
        nq_nx[l]  = nq_in[l];
        for (int k = 0; k < DIV_STEPS; k++) begin
          trial = {rem_nx[l], nq_nx[l][NUM_W-1]};
          if (trial >= {1'b0, divisor[l]}) begin
            rem_nx[l] = DIV_W'(trial - {1'b0, divisor[l]});
            nq_nx[l]  = {nq_nx[l][NUM_W-2:0], 1'b1};
          end else begin
            rem_nx[l] = trial[DIV_W-1:0];
            nq_nx[l]  = {nq_nx[l][NUM_W-2:0], 1'b0};
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v_q[s] <= 1'b0;
      end else if (en) begin
        v_q[s] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        for (int l = 0; l < 3; l++) begin
          rem_q[s][l] <= rem_nx[l];
          nq_q[s][l]  <= nq_nx[l];
        end
      end
    end
  end

  assign out_valid = v_q[DIV_STAGES-1];
  for (genvar l = 0; l < 3; l++) begin : g_out
    assign quo[l] = nq_q[DIV_STAGES-1][l][T_W-1:0];
  end

endmodule

@@ rtl/core/srgb_lab_cbrt.sv @@
// ---------------------------------------------------------------------------
// srgb_lab_cbrt
// Bit-by-bit cube root, three lanes, one square and one cube stage per bit.
// ---------------------------------------------------------------------------
module srgb_lab_cbrt (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            en,
  input  logic                            in_valid,
  input  logic [srgb_lab_pkg::T_W-1:0]    t_in [3],
  output logic                            out_valid,
  output logic [srgb_lab_pkg::ROOT_W-1:0] root [3],
  output logic [srgb_lab_pkg::T_W-1:0]    t_out [3]
);
  import srgb_lab_pkg::*;

  localparam int CubeFullW = SQ_W + ROOT_W;

  logic [ROOT_W-1:0] ch  [ROOT_W][3];
  logic [SQ_W-1:0]   sqh [ROOT_W][3];
  logic [ROOT_W-1:0] rh  [ROOT_W][3];
  logic [T_W-1:0]    th  [ROOT_W][3];
  logic              vh  [ROOT_W];
  logic [ROOT_W-1:0] rf  [ROOT_W][3];
  logic [T_W-1:0]    tf  [ROOT_W][3];
  logic              vf  [ROOT_W];

  for (genvar k = 0; k < ROOT_W; k++) begin : g_bit
    localparam int Bit = ROOT_W - 1 - k;
    logic [ROOT_W-1:0] r_in [3];
    logic [T_W-1:0]    t_prev [3];
    logic              v_in;
    logic [ROOT_W-1:0] cand [3];
    logic [2*ROOT_W-1:0] sq_full [3];
    logic [CubeFullW-1:0] cube_full [3];

    if (k == 0) begin : g_first
      assign v_in = in_valid;
      for (genvar l = 0; l < 3; l++) begin : g_lane
        assign r_in[l]   = '0;
        assign t_prev[l] = t_in[l];
      end
    end else begin : g_rest
      assign v_in = vf[k-1];
      for (genvar l = 0; l < 3; l++) begin : g_lane
        assign r_in[l]   = rf[k-1][l];
        assign t_prev[l] = tf[k-1][l];
      end
    end

    for (genvar l = 0; l < 3; l++) begin : g_math
      assign cand[l]      = r_in[l] | (ROOT_W'(1) << Bit);
      assign sq_full[l]   = (2*ROOT_W)'(cand[l]) * (2*ROOT_W)'(cand[l]);
      assign cube_full[l] = CubeFullW'(sqh[k][l]) * CubeFullW'(ch[k][l]);
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vh[k] <= 1'b0;
        vf[k] <= 1'b0;
      end else if (en) begin
        vh[k] <= v_in;
        vf[k] <= vh[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        for (int l = 0; l < 3; l++) begin
          ch[k][l]  <= cand[l];
          sqh[k][l] <= sq_full[l][QBITS +: SQ_W];
          rh[k][l]  <= r_in[l];
          th[k][l]  <= t_prev[l];
          tf[k][l]  <= th[k][l];
          if (T_W'(cube_full[l][QBITS +: CUBE_W]) <= th[k][l]) begin
            rf[k][l] <= ch[k][l];
          end else begin
            rf[k][l] <= rh[k][l];
          end
        end
      end
    end
  end

  assign out_valid = vf[ROOT_W-1];
  for (genvar l = 0; l < 3; l++) begin : g_out
    assign root[l]  = rf[ROOT_W-1][l];
    assign t_out[l] = tf[ROOT_W-1][l];
  end

endmodule

@@ rtl/core/srgb_lab_output.sv @@
// ---------------------------------------------------------------------------
// srgb_lab_output
// Linear segment of the Lab function, L/a/b forming, rounding, saturation and
// the output register with its skid stage.
// ---------------------------------------------------------------------------
module srgb_lab_output (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  input  logic [srgb_lab_pkg::ROOT_W-1:0] root [3],
  input  logic [srgb_lab_pkg::T_W-1:0]    t_in [3],
  input  logic                            m_tready,
  output logic                            m_tvalid,
  output srgb_lab_pkg::lab_out_t          result,
  output logic                            advance
);
  import srgb_lab_pkg::*;

  localparam int MulW = PROD_W + RECIP_W;

  logic [PROD_W-1:0]  prod [3];
  logic               below [3];
  logic [ROOT_W-1:0]  r0 [3];
  logic [ROOT_W-1:0]  f1 [3];
  logic signed [LAB_W-1:0] v_l;
  logic signed [LAB_W-1:0] v_a;
  logic signed [LAB_W-1:0] v_b;
  logic               v0;
  logic               v1;
  logic               v2;
  logic [MulW-1:0]    quot_full [3];
  logic signed [LAB_W-1:0] fs [3];
  lab_out_t           rounded;
  lab_out_t           skid;
  logic               skid_valid;
  logic               take;

  function automatic logic [OUT_W-1:0] round_sat(logic signed [LAB_W-1:0] v);
    logic signed [LAB_W-1:0] s;
    logic signed [LAB_W-17:0] q;
    s = v + LAB_W'(32768);
    q = s[LAB_W-1:16];
    if (q > (LAB_W-16)'(32767)) begin
      return 16'h7FFF;
    end else if (q < -(LAB_W-16)'(32768)) begin
      return 16'h8000;
    end
    return q[OUT_W-1:0];
  endfunction

  assign advance = !skid_valid;
  assign take    = v2 && advance;

  for (genvar l = 0; l < 3; l++) begin : g_lane
    assign quot_full[l] = MulW'(prod[l]) * MulW'(RECIP_1000);
    assign fs[l] = $signed(LAB_W'(f1[l]));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else if (advance) begin
      v0 <= in_valid;
      v1 <= v0;
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      for (int l = 0; l < 3; l++) begin
        prod[l]  <= LIN_SLOPE * PROD_W'(t_in[l][KNEE_BITS-1:0]);
        below[l] <= (t_in[l] <= KNEE_T);
        r0[l]    <= root[l];
        if (below[l]) begin
          f1[l] <= ROOT_W'(quot_full[l][RECIP_SHIFT +: LF_W] + LIN_OFFSET);
        end else begin
          f1[l] <= r0[l];
        end
      end
      v_l <= fs[1] * LAB_W'(L_SCALE) - LAB_W'(L_OFFSET);
      v_a <= (fs[0] - fs[1]) * LAB_W'(A_SCALE);
      v_b <= (fs[1] - fs[2]) * LAB_W'(B_SCALE);
    end
  end

  always_comb begin
    rounded.lightness   = round_sat(v_l);
    rounded.green_red   = round_sat(v_a);
    rounded.blue_yellow = round_sat(v_b);
  end

  // The skid register only fills when the output register is held.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid   <= 1'b0;
      skid_valid <= 1'b0;
    end else if (take) begin
      if (!m_tvalid || m_tready) begin
        m_tvalid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (m_tvalid && m_tready) begin
      if (skid_valid) begin
        skid_valid <= 1'b0;
      end else begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      if (!m_tvalid || m_tready) begin
        result <= rounded;
      end else begin
        skid <= rounded;
      end
    end else if (m_tvalid && m_tready && skid_valid) begin
      result <= skid;
    end
  end

endmodule

@@ rtl/core/srgb_lab_checker.sv @@
// ---------------------------------------------------------------------------
// srgb_lab_checker
// Port-level checks of the converter's stream handshakes.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module srgb_lab_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                s_tready,
  input logic                                m_tvalid,
  input logic                                m_tready,
  input logic [srgb_lab_pkg::OUT_DATA_W-1:0] m_tdata
);

  // A result must stay offered and unchanged until it is taken.
  `ASSERT_NEXT(a_hold_valid, clk, rst, m_tvalid && !m_tready, m_tvalid)
  `ASSERT_NEXT(a_hold_data, clk, rst, m_tvalid && !m_tready, $stable(m_tdata))

  // With no result waiting the skid stage is empty, so input is taken.
  `ASSERT_IMPLY(a_ready_when_empty, clk, rst, !m_tvalid, s_tready)

  // Input backs off only after the output was held in the previous cycle.
  `ASSERT_IMPLY(a_stall_cause, clk, rst, !s_tready, m_tvalid && $past(!m_tready))

  `ASSERT_AFTER_RESET(a_reset_empty, clk, rst, !m_tvalid && s_tready)

endmodule

bind srgb_to_cielab_unit srgb_lab_checker u_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

@@ tb/sv/srgb_to_cielab_unit_test.sv @@
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// srgb_to_cielab_unit_test
// Drives pixels into the sRGB to CIELAB converter under random idling and
// back pressure. An independent fixed-point model of the conversion predicts
// L, a and b for every pixel, and a checker compares each returned transfer.
// ---------------------------------------------------------------------------
module srgb_to_cielab_unit_test;
  import srgb_lab_pkg::*;

  localparam int ChanBits = 8;
  localparam int Latency  = 76;

  logic                  clk;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [23:0]           s_tdata;   // red, green, blue
  logic                  m_tvalid;
  logic                  m_tready;
  logic [OUT_DATA_W-1:0] m_tdata;   // lightness, green_red, blue_yellow
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [WHITE_W-1:0]    cfg_data;

  srgb_to_cielab_unit #(.CHANNEL_BITS(ChanBits)) dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Predictor copy of the reference white.
  longint unsigned white_ref [3];

  // Expected L, a, b words, oldest first.
  lab_out_t pending_lab [$];

  int  mismatches;
  bit  sink_hold;     // forces the receiver to stall
  bit  sink_smooth;   // receiver takes every result when set
  bit  source_smooth; // sender never idles when set

  // ---------------------------------------------------------------------------
  // Conversion predictor, written in Q24 fixed point.
  // ---------------------------------------------------------------------------
  function automatic longint unsigned q24_mul(longint unsigned x, longint unsigned y);
    return (x * y) >> 24;
  endfunction

  // Inverse sRGB gamma of one channel, value over 255.
  function automatic longint unsigned to_linear(longint unsigned c);
    longint unsigned full, u, sq, root, trial;
    full = 255;
    if (100000 * c > 4045 * full) begin
      u = ((1000 * c + 55 * full) << 24) / (1055 * full);
      sq = q24_mul(u, u);
      root = 0;
      for (int k = 24; k >= 0; k--) begin
        trial = root | (64'd1 << k);
        if (q24_mul(q24_mul(q24_mul(q24_mul(trial, trial), trial), trial), trial) <= sq)
          root = trial;
      end
      return q24_mul(sq, root);
    end
    return ((c * 100) << 24) / (full * 1292);
  endfunction

  // CIELAB companding: cube root above the knee, straight line below.
  function automatic longint unsigned lab_compand(longint unsigned t);
    longint unsigned root, trial;
    if (t * 1000000 > (64'd8856 << 24)) begin
      root = 0;
      for (int k = 28; k >= 0; k--) begin
        trial = root | (64'd1 << k);
        if (q24_mul(q24_mul(trial, trial), trial) <= t) root = trial;
      end
      return root;
    end
    return (7787 * t) / 1000 + (64'd16 << 24) / 116;
  endfunction

  // Half-up rounding from Q24 to Q8, then saturation to 16 bits.
  function automatic logic [15:0] round_sat(longint v);
    longint q;
    q = (v + 32768) >>> 16;
    if (q > 32767) q = 32767;
    if (q < -32768) q = -32768;
    return q[15:0];
  endfunction

  function automatic lab_out_t convert_pixel(logic [7:0] red, logic [7:0] green,
                                             logic [7:0] blue);
    longint unsigned coef [3][3];
    longint unsigned lin [3];
    longint unsigned sum, t, w;
    longint f [3];
    lab_out_t res;
    coef = '{'{4124, 3576, 1805}, '{2126, 7152, 722}, '{193, 1192, 9505}};
    lin[0] = to_linear(red);
    lin[1] = to_linear(green);
    lin[2] = to_linear(blue);
    for (int i = 0; i < 3; i++) begin
      w = (white_ref[i] == 0) ? 1 : white_ref[i];
      sum = coef[i][0] * lin[0] + coef[i][1] * lin[1] + coef[i][2] * lin[2];
      t = (sum * 64) / (25 * w);
      f[i] = longint'(lab_compand(t));
    end
    res.lightness   = round_sat(116 * f[1] - (longint'(16) << 24));
    res.green_red   = round_sat(500 * (f[0] - f[1]));
    res.blue_yellow = round_sat(200 * (f[1] - f[2]));
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Clock and run limit.
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("FAIL");
    $finish;
  end

  // Random gap length: mostly zero or short, now and then long.
  function automatic int random_gap();
    int roll;
    roll = $urandom_range(99);
    if (roll < 55) return 0;
    if (roll < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  // ---------------------------------------------------------------------------
  // Sender: offers one pixel and holds it until the transfer completes.
  // ---------------------------------------------------------------------------
  task automatic send_pixel(logic [7:0] red, logic [7:0] green, logic [7:0] blue);
    int gap;
    gap = source_smooth ? 0 : random_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {blue, green, red};
    // The expectation is queued at the accepting edge, before the checker
    // could possibly see the result.
    do @(posedge clk); while (!s_tready);
    pending_lab.push_back(convert_pixel(red, green, blue));
    @(negedge clk);
  endtask

  task automatic stop_sending();
    s_tvalid <= 1'b0;
  endtask

  task automatic drain();
    int guard;
    stop_sending();
    guard = 0;
    while (pending_lab.size() != 0 && guard < 200000) begin
      @(negedge clk);
      guard++;
    end
    // Let any result still in the pipeline surface before a register changes.
    repeat (Latency + 10) @(negedge clk);
  endtask

  // Register write, only while the pipeline is empty. The caller drops
  // cfg_valid once its last write is done.
  task automatic write_white(cfg_index_t idx, logic [WHITE_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    white_ref[idx] = value;
    @(negedge clk);
  endtask

  task automatic set_white(logic [WHITE_W-1:0] wx, logic [WHITE_W-1:0] wy,
                           logic [WHITE_W-1:0] wz);
    write_white(REG_WHITE_X, wx);
    write_white(REG_WHITE_Y, wy);
    write_white(REG_WHITE_Z, wz);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_random_pixels(int count);
    for (int n = 0; n < count; n++)
      send_pixel(8'($urandom_range(255)), 8'($urandom_range(255)),
                 8'($urandom_range(255)));
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: random stalls, plus a forced hold used for back pressure.
  // ---------------------------------------------------------------------------
  initial begin
    int gap;
    m_tready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (sink_hold) begin
        m_tready <= 1'b0;
        @(negedge clk);
      end else begin
        gap = sink_smooth ? 0 : random_gap();
        if (gap > 0) begin
          m_tready <= 1'b0;
          repeat (gap) @(negedge clk);
        end
        m_tready <= 1'b1;
        @(negedge clk);
      end
    end
  end

  // Checker: every accepted result against the oldest expectation.
  always @(posedge clk) begin
    lab_out_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata;
      if (pending_lab.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result transfer %h", m_tdata);
      end else begin
        want = pending_lab.pop_front();
        if (got.lightness !== want.lightness || got.green_red !== want.green_red ||
            got.blue_yellow !== want.blue_yellow) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: L %h/%h a %h/%h b %h/%h (expected/actual)",
                     want.lightness, got.lightness, want.green_red, got.green_red,
                     want.blue_yellow, got.blue_yellow);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Test tasks.
  // ---------------------------------------------------------------------------

  // Channel extremes, both gamma segments and the knee, at the D65 white.
  task automatic test_directed_pixels();
    logic [7:0] levels [8];
    levels = '{8'd0, 8'd1, 8'd10, 8'd11, 8'd128, 8'd170, 8'd254, 8'd255};
    send_pixel(8'd0, 8'd0, 8'd0);
    send_pixel(8'd255, 8'd255, 8'd255);
    send_pixel(8'd255, 8'd0, 8'd0);
    send_pixel(8'd0, 8'd255, 8'd0);
    send_pixel(8'd0, 8'd0, 8'd255);
    send_pixel(8'h55, 8'hAA, 8'h55);
    send_pixel(8'hAA, 8'h55, 8'hAA);
    for (int i = 0; i < 8; i++) send_pixel(levels[i], levels[7 - i], levels[(i + 3) % 8]);
    drain();
  endtask

  // Extreme and zero white values: tiny whites saturate the outputs, a zero
  // register is treated as the smallest nonzero white.
  task automatic test_white_extremes();
    set_white(15'd256, 15'd256, 15'd256);
    send_pixel(8'd255, 8'd255, 8'd255);
    send_pixel(8'd255, 8'd0, 8'd128);
    send_random_pixels(20);
    drain();
    set_white(15'h7FFF, 15'h7FFF, 15'h7FFF);
    send_pixel(8'd255, 8'd255, 8'd255);
    send_pixel(8'd3, 8'd0, 8'd255);
    send_random_pixels(20);
    drain();
    set_white(15'd0, 15'h7FFF, 15'd0);
    send_pixel(8'd0, 8'd0, 8'd0);
    send_pixel(8'd0, 8'd1, 8'd0);
    send_pixel(8'd255, 8'd255, 8'd255);
    send_random_pixels(10);
    drain();
    set_white(15'h7FFF, 15'd0, 15'd256);
    send_random_pixels(10);
    drain();
  endtask

  // Bulk random pixels over several random white points.
  task automatic test_random_pixels();
    for (int phase = 0; phase < 4; phase++) begin
      set_white(15'($urandom_range(32767, 256)), 15'($urandom_range(32767, 256)),
                15'($urandom_range(32767, 256)));
      send_random_pixels(180);
      drain();
    end
    set_white(WHITE_X_RST, WHITE_Y_RST, WHITE_Z_RST);
    sink_smooth = 1'b1;
    source_smooth = 1'b1;
    send_random_pixels(150);
    sink_smooth = 1'b0;
    source_smooth = 1'b0;
    send_random_pixels(50);
    drain();
  endtask

  // Receiver holds off long enough that the pipeline fills and s_tready
  // drops; the sender keeps offering pixels the whole time.
  task automatic test_back_pressure();
    sink_hold = 1'b1;
    source_smooth = 1'b1;
    fork
      begin
        repeat (Latency + 60) @(negedge clk);
        sink_hold = 1'b0;
      end
      send_random_pixels(150);
    join
    source_smooth = 1'b0;
    drain();
  endtask

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_WHITE_X;
    cfg_data = '0;
    mismatches = 0;
    sink_hold = 1'b0;
    sink_smooth = 1'b0;
    source_smooth = 1'b0;
    white_ref[0] = WHITE_X_RST;
    white_ref[1] = WHITE_Y_RST;
    white_ref[2] = WHITE_Z_RST;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_directed_pixels();
    test_white_extremes();
    test_back_pressure();
    test_random_pixels();

    if (mismatches == 0 && pending_lab.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+rtl/core
rtl/core/srgb_lab_pkg.sv
rtl/core/srgb_lab_linearize.sv
rtl/core/srgb_lab_divide.sv
rtl/core/srgb_lab_cbrt.sv
rtl/core/srgb_lab_output.sv
rtl/core/srgb_to_cielab_unit.sv
rtl/core/srgb_lab_checker.sv
tb/sv/srgb_to_cielab_unit_test.sv
